// File: hdl/echoing_line_editor_defines.svh
// Assertion macros shared by the checker files of the echoing line editor.
// Depends on nothing; each macro expects clk and rst_n in the including scope.
`ifndef ECHOING_LINE_EDITOR_DEFINES_SVH
`define ECHOING_LINE_EDITOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ELED_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line editor check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ELED_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line editor check failed");

`endif

// File: hdl/eled_pkg.sv
// Package of the echoing line editor: sizes, key codes, banner table and the
// command/status structs between controller and datapath. Depends on nothing.
package eled_pkg;

    localparam int LINE_DEPTH = 32;
    localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int BANNER_LEN = 20;
    localparam int BANNER_W   = $clog2(BANNER_LEN);
    localparam int CNT_W      = (BANNER_W > ADDR_W) ? BANNER_W : ADDR_W;

    localparam logic [7:0] KEY_DEL = 8'h7f;
    localparam logic [7:0] KEY_CR  = 8'h0d;
    localparam logic [7:0] KEY_LF  = 8'h0a;

    // Sources of a transmitted byte
    localparam logic [2:0] SEL_BANNER = 3'd0;
    localparam logic [2:0] SEL_LINE   = 3'd1;
    localparam logic [2:0] SEL_RX     = 3'd2;
    localparam logic [2:0] SEL_DEL    = 3'd3;
    localparam logic [2:0] SEL_LF     = 3'd4;
    localparam logic [2:0] SEL_CR     = 3'd5;

    typedef struct packed {
        logic       rx_load;
        logic       emit;
        logic [2:0] emit_sel;
        logic       emit_last;
        logic       cnt_clr;
        logic       cnt_inc;
        logic       ram_rd;
        logic       ram_wr;
        logic       idx_inc;
        logic       idx_dec;
        logic       idx_clr;
    } cmd_t;

    typedef struct packed {
        logic slot_free;
        logic rx_is_cr;
        logic rx_is_del;
        logic idx_zero;
        logic idx_room;
        logic cnt_banner_end;
        logic cnt_at_idx;
        logic rd_zero;
    } stat_t;

    // "\n\rReceived Command: "
    function automatic logic [7:0] banner_char(input logic [BANNER_W-1:0] pos);
        logic [7:0] ch;
        unique case (pos)
            5'd0:    ch = 8'h0a;
            5'd1:    ch = 8'h0d;
            5'd2:    ch = 8'h52;
            5'd3:    ch = 8'h65;
            5'd4:    ch = 8'h63;
            5'd5:    ch = 8'h65;
            5'd6:    ch = 8'h69;
            5'd7:    ch = 8'h76;
            5'd8:    ch = 8'h65;
            5'd9:    ch = 8'h64;
            5'd10:   ch = 8'h20;
            5'd11:   ch = 8'h43;
            5'd12:   ch = 8'h6f;
            5'd13:   ch = 8'h6d;
            5'd14:   ch = 8'h6d;
            5'd15:   ch = 8'h61;
            5'd16:   ch = 8'h6e;
            5'd17:   ch = 8'h64;
            5'd18:   ch = 8'h3a;
            5'd19:   ch = 8'h20;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// File: hdl/echoing_line_editor.sv
// Top level of the echoing line editor: joins controller and datapath.
// Depends on eled_pkg, eled_ctrl, eled_dpath (and eled_ram below it).
//
//   channel | handshake          | payload
//   --------+--------------------+-----------------------
//   rx      | rx_valid, rx_stall | rx_byte[7:0]
//   tx      | tx_valid, tx_stall | tx_byte[7:0], last
//
// Ordinary byte: accept, then decode, which also emits its echo or delete.
// Carriage return: accept, decode, the 20 banner characters, then per stored byte
// a RAM read and then an emit, a check for the line end, and the LF, CR tail.
// Reset clears index, sequencer and output valid; the store keeps old bytes,
// but nothing at or past the write index is ever read.
// A tx stall holds emission; rx_stall is high while a request is in work.
module echoing_line_editor (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    output logic       tx_valid,
    input  logic       tx_stall,
    output logic [7:0] tx_byte,
    output logic       last
);
    import eled_pkg::*;

    cmd_t  cmd;
    stat_t st;

    // sequencer: accepts requests, decides echo, delete, drop or report
    eled_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_stall (rx_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // storage, index, walk counter and the output register
    eled_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_byte  (rx_byte),
        .cmd      (cmd),
        .st       (st),
        .tx_stall (tx_stall),
        .tx_valid (tx_valid),
        .tx_byte  (tx_byte),
        .last     (last)
    );

endmodule

// File: hdl/eled_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module eled_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/eled_ctrl.sv
// Controller of the echoing line editor: input handshake and the sequencer
// that steps echo and report emission. Depends on eled_pkg.
module eled_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rx_valid,
    output logic                 rx_stall,
    input  eled_pkg::stat_t      st,
    output eled_pkg::cmd_t       cmd
);
    import eled_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DECODE  = 3'd1;
    localparam logic [2:0] S_BANNER  = 3'd2;
    localparam logic [2:0] S_LREAD   = 3'd3;
    localparam logic [2:0] S_LEMIT   = 3'd4;
    localparam logic [2:0] S_TAIL_LF = 3'd5;
    localparam logic [2:0] S_TAIL_CR = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign rx_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (rx_valid)
                begin
                    cmd.rx_load = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (st.rx_is_cr)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_BANNER;
                end
                else if (st.rx_is_del && !st.idx_zero)
                begin
                    if (st.slot_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_sel  = SEL_DEL;
                        cmd.emit_last = 1'b1;
                        cmd.idx_dec   = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else if (st.idx_room)
                begin
                    if (st.slot_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_sel  = SEL_RX;
                        cmd.emit_last = 1'b1;
                        cmd.ram_wr    = 1'b1;
                        cmd.idx_inc   = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    // drop: line full
                    state_next = S_IDLE;
                end
            end
            S_BANNER:
            begin
                if (st.slot_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = SEL_BANNER;
                    if (st.cnt_banner_end)
                    begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = S_LREAD;
                    end
                    else
                    begin
                        cmd.cnt_inc = 1'b1;
                    end
                end
            end
            S_LREAD:
            begin
                if (st.cnt_at_idx)
                begin
                    state_next = S_TAIL_LF;
                end
                else
                begin
                    cmd.ram_rd = 1'b1;
                    state_next = S_LEMIT;
                end
            end
            S_LEMIT:
            begin
                if (st.rd_zero)
                begin
                    state_next = S_TAIL_LF;
                end
                else if (st.slot_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = SEL_LINE;
                    cmd.cnt_inc  = 1'b1;
                    state_next   = S_LREAD;
                end
            end
            S_TAIL_LF:
            begin
                if (st.slot_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = SEL_LF;
                    state_next   = S_TAIL_CR;
                end
            end
            S_TAIL_CR:
            begin
                if (st.slot_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = SEL_CR;
                    cmd.emit_last = 1'b1;
                    cmd.idx_clr   = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/eled_dpath.sv
// Datapath of the echoing line editor: request register, write index, walk
// counter, line store RAM and the output register. Depends on eled_pkg, eled_ram.
module eled_dpath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           rx_byte,
    input  eled_pkg::cmd_t       cmd,
    output eled_pkg::stat_t      st,
    input  logic                 tx_stall,
    output logic                 tx_valid,
    output logic [7:0]           tx_byte,
    output logic                 last
);
    import eled_pkg::*;

    logic [7:0]       rx_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [ADDR_W-1:0] idx_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;
    logic [7:0]       emit_byte;
    logic [7:0]       rd_data;

    eled_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.ram_wr),
        .wr_addr (idx_reg),
        .wr_data (rx_reg),
        .rd_en   (cmd.ram_rd),
        .rd_addr (cnt_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.rx_load)
        begin
            rx_reg <= rx_byte;
        end
        if (cmd.emit)
        begin
            out_byte_reg <= emit_byte;
            out_last_reg <= cmd.emit_last;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + 1'b1;
        end
        else if (cmd.idx_dec)
        begin
            idx_next = idx_reg - 1'b1;
        end

        cnt_next = cnt_reg;
        if (cmd.cnt_clr)
        begin
            cnt_next = '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + 1'b1;
        end

        // hold a stalled byte, drop it once taken, load a new one when told
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!tx_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        case (cmd.emit_sel)
            SEL_BANNER: emit_byte = banner_char(cnt_reg[BANNER_W-1:0]);
            SEL_LINE:   emit_byte = rd_data;
            SEL_RX:     emit_byte = rx_reg;
            SEL_DEL:    emit_byte = KEY_DEL;
            SEL_LF:     emit_byte = KEY_LF;
            SEL_CR:     emit_byte = KEY_CR;
            default:    emit_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        st.slot_free      = !out_valid_reg || !tx_stall;
        st.rx_is_cr       = (rx_reg == KEY_CR);
        st.rx_is_del      = (rx_reg == KEY_DEL);
        st.idx_zero       = (idx_reg == '0);
        st.idx_room       = (idx_reg < ADDR_W'(LINE_DEPTH - 1));
        st.cnt_banner_end = (cnt_reg == CNT_W'(BANNER_LEN - 1));
        st.cnt_at_idx     = (cnt_reg == CNT_W'(idx_reg));
        st.rd_zero        = (rd_data == 8'h00);
    end

    assign tx_valid = out_valid_reg;
    assign tx_byte  = out_byte_reg;
    assign last     = out_last_reg;

endmodule

// File: hdl/eled_checker.sv
// Port-level checker of the echoing line editor and its bind to the top level.
// Depends on echoing_line_editor_defines.svh.
`include "echoing_line_editor_defines.svh"

module eled_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       rx_valid,
    input logic       rx_stall,
    input logic [7:0] rx_byte,
    input logic       tx_valid,
    input logic       tx_stall,
    input logic [7:0] tx_byte,
    input logic       last
);

    // a stalled result holds
    `ELED_ASSERT_NXT(a_tx_hold, tx_valid && tx_stall, tx_valid && $stable(tx_byte) && $stable(last))
    // a stalled request holds
    `ELED_ASSERT_NXT(a_rx_hold, rx_valid && rx_stall, rx_valid && $stable(rx_byte))
    // an accepted request blocks the next one
    `ELED_ASSERT_NXT(a_busy_after_accept, rx_valid && !rx_stall, rx_stall)
    // when idle, any pending result is the final one of its request
    `ELED_ASSERT_IMP(a_idle_pending_last, !rx_stall && tx_valid, last)

endmodule

bind echoing_line_editor eled_checker u_eled_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .rx_byte  (rx_byte),
    .tx_valid (tx_valid),
    .tx_stall (tx_stall),
    .tx_byte  (tx_byte),
    .last     (last)
);
